[src/rdiv_pkg.sv]
// Package for the restoring divider: operand width, word types and the
// per-stage pipeline record. Used by every file of the block.
package rdiv_pkg;

  localparam int WIDTH = 16;

  typedef struct packed {
    logic [WIDTH-1:0] dividend;
    logic [WIDTH-1:0] divisor;
  } operand_t;

  typedef struct packed {
    logic [WIDTH-1:0] quotient;
    logic [WIDTH-1:0] remainder;
  } result_t;

  // One word in flight: the partial remainder, the divisor, and a shift
  // register that loses one dividend bit and gains one quotient bit per step.
  typedef struct packed {
    logic [WIDTH-1:0] rem;
    logic [WIDTH-1:0] acc;
    logic [WIDTH-1:0] den;
  } stage_t;

endpackage

[src/restoring_divider.sv]
// Top level of the pipelined unsigned restoring divider.
// Depends on rdiv_pkg and rdiv_step.
//
// The divider takes one dividend and divisor word in every clock cycle and
// never raises busy. Each word passes through one register stage per quotient
// bit, so its result appears on the result port with done high for one cycle
// only. There is no way to hold a result back, so the receiver must take it in
// that cycle. The chain holds 16 subtract-and-restore stages. Division by zero
// returns an all-ones quotient and the dividend as remainder, with no flag.
module restoring_divider (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  rdiv_pkg::operand_t operands,
  output logic               done,
  output rdiv_pkg::result_t  result
);
  import rdiv_pkg::*;

  stage_t           pipe [0:WIDTH];
  logic [WIDTH:0]   vld;

  assign busy = 1'b0;

  assign vld[0]       = start;
  assign pipe[0].rem  = '0;
  assign pipe[0].acc  = operands.dividend;
  assign pipe[0].den  = operands.divisor;

  for (genvar i = 0; i < WIDTH; i++) begin : g_step
    rdiv_step u_step (
      .clk     (clk),
      .rst     (rst),
      .vld_in  (vld[i]),
      .stg_in  (pipe[i]),
      .vld_out (vld[i+1]),
      .stg_out (pipe[i+1])
    );
  end

  assign done             = vld[WIDTH];
  assign result.quotient  = pipe[WIDTH].acc;
  assign result.remainder = pipe[WIDTH].rem;

endmodule

[src/rdiv_step.sv]
// One subtract-and-restore step of the divider with its pipeline register.
// Depends on rdiv_pkg.
module rdiv_step (
  input  logic            clk,
  input  logic            rst,
  input  logic            vld_in,
  input  rdiv_pkg::stage_t stg_in,
  output logic            vld_out,
  output rdiv_pkg::stage_t stg_out
);
  import rdiv_pkg::*;

  logic             top;
  logic [WIDTH-1:0] shifted;
  logic [WIDTH+1:0] diff;
  logic             fits;
  stage_t           stg_next;

  always_comb begin
    top     = stg_in.rem[WIDTH-1];
    shifted = {stg_in.rem[WIDTH-2:0], stg_in.acc[WIDTH-1]};
    diff    = {1'b0, top, shifted} - {2'b00, stg_in.den};
    fits    = ~diff[WIDTH+1];
    stg_next.rem = fits ? diff[WIDTH-1:0] : shifted;
    stg_next.acc = {stg_in.acc[WIDTH-2:0], fits};
    stg_next.den = stg_in.den;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_out <= 1'b0;
    end else begin
      vld_out <= vld_in;
    end
  end

  always_ff @(posedge clk) begin
    stg_out <= stg_next;
  end

endmodule

[src/rdiv_checker.sv]
// Port-level checks for the restoring divider, bound to its top level.
// Depends on rdiv_pkg and restoring_divider.
module rdiv_checker (
  input logic               clk,
  input logic               rst,
  input logic               start,
  input logic               busy,
  input rdiv_pkg::operand_t operands,
  input logic               done,
  input rdiv_pkg::result_t  result
);
  import rdiv_pkg::*;

  a_never_busy: assert property (@(posedge clk) disable iff (rst) !busy)
    else $error("busy was raised");

  a_done_follows_start: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, WIDTH))
    else $error("result without a matching accepted word");

  a_rem_below_divisor: assert property (@(posedge clk) disable iff (rst)
    done |-> ($past(operands.divisor, WIDTH) == '0 ||
              result.remainder < $past(operands.divisor, WIDTH)))
    else $error("remainder not below divisor");

  a_zero_divisor: assert property (@(posedge clk) disable iff (rst)
    (done && $past(operands.divisor, WIDTH) == '0) |->
      (result.quotient == '1 && result.remainder == $past(operands.dividend, WIDTH)))
    else $error("wrong result for zero divisor");

endmodule

bind restoring_divider rdiv_checker u_rdiv_checker (
  .clk      (clk),
  .rst      (rst),
  .start    (start),
  .busy     (busy),
  .operands (operands),
  .done     (done),
  .result   (result)
);
